### hw/rtl/cbm_pkg.sv
// Shared types and constants for the 4A50 cartridge bank mapper.
package cbm_pkg;

   // Store depths
   localparam int unsigned ROM_DEPTH_DEF = 65536;
   localparam int unsigned RAM_DEPTH_DEF = 32768;

   // Payload widths
   localparam int unsigned REQ_TYPE_W  = 2;
   localparam int unsigned BUS_ADDR_W  = 16;
   localparam int unsigned DEC_ADDR_W  = 13;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned OFFSET_W    = 16;
   localparam int unsigned PEER_W      = 2;

   // Window flag bit positions
   localparam int unsigned WIN_LOW  = 0;
   localparam int unsigned WIN_MID  = 1;
   localparam int unsigned WIN_HIGH = 2;

   // Request codes
   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_READ  = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_LOAD  = 2'd2
   } req_kind_type;

   // Peer chip that answers a low access
   typedef enum logic [PEER_W-1:0] {
      PEER_NONE = 2'd0,
      PEER_TIA  = 2'd1,
      PEER_RIOT = 2'd2
   } peer_target_type;

   // Banking state
   typedef struct packed {
      logic [OFFSET_W-1:0]   low_off;
      logic [OFFSET_W-1:0]   mid_off;
      logic [OFFSET_W-1:0]   high_off;
      logic [2:0]            win_rom;
      logic [BYTE_W-1:0]     prev_byte;
      logic [DEC_ADDR_W-1:0] prev_addr;
   } bank_state_type;

endpackage

### hw/rtl/cbm_req_if.sv
// Request and response channel interfaces of the bank mapper.
interface cbm_req_if
   import cbm_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [BUS_ADDR_W-1:0] address;
   logic [BYTE_W-1:0]     write_data;
   logic [BYTE_W-1:0]     peer_data;
   logic [BYTE_W-1:0]     bus_state;

   modport source (output valid, req_type, address, write_data, peer_data, bus_state,
                   input ready);
   modport sink   (input valid, req_type, address, write_data, peer_data, bus_state,
                   output ready);
endinterface

interface cbm_rsp_if
   import cbm_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] read_data;
   logic [PEER_W-1:0] peer_target;

   modport source (output valid, read_data, peer_target, input ready);
   modport sink   (input valid, read_data, peer_target, output ready);
endinterface

### hw/rtl/cartridge_bank_mapper_4a50.sv
// Top level of the 4A50 cartridge bank mapper: decode, ROM/RAM stores, hotspot banking.
//
//  channel    dir   handshake      payload
//  req_chan   in    valid/ready    req_type, address, write_data, peer_data, bus_state
//  rsp_chan   out   valid/ready    read_data, peer_target
//
// One transaction per cycle if unstalled; a response passes s1, then the rsp register.
// The store read happens at acceptance with banking forwarded from the transaction in the
// access stage; the bank update and last-byte capture happen as that stage retires.
// Reset (synchronous) restores banking state; ROM and RAM contents are kept.
// A stalled response holds the access stage; acceptance resumes as soon as it drains.
module cartridge_bank_mapper_4a50
   import cbm_pkg::*;
#(
   parameter int unsigned ROM_DEPTH = ROM_DEPTH_DEF,
   parameter int unsigned RAM_DEPTH = RAM_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   cbm_req_if.sink   req_chan,
   cbm_rsp_if.source rsp_chan
);

   localparam int unsigned RomAddrWidth = $clog2(ROM_DEPTH);
   localparam int unsigned RamAddrWidth = $clog2(RAM_DEPTH);

   // Storage
   logic [BYTE_W-1:0] rom_mem [ROM_DEPTH];
   logic [BYTE_W-1:0] ram_mem [RAM_DEPTH];
   logic [BYTE_W-1:0] rom_q_ff;
   logic [BYTE_W-1:0] ram_q_ff;

   // Banking state
   bank_state_type state_ff, state_in, state_upd, state_fwd;

   // Access stage
   logic                  s1_valid_ff, s1_valid_in;
   logic [REQ_TYPE_W-1:0] s1_kind_ff;
   logic [DEC_ADDR_W-1:0] s1_addr_ff;
   logic [BYTE_W-1:0]     s1_wdata_ff;
   logic [BYTE_W-1:0]     s1_peer_ff;
   logic [BYTE_W-1:0]     s1_bus_ff;
   logic                  s1_rom_ff;

   // Response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]     read_data_ff;
   peer_target_type       peer_target_ff;

   logic out_free, s1_move, accept;

   // Handshake
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_move        = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign accept         = req_chan.valid && req_chan.ready;
   assign state_fwd      = s1_move ? state_upd : state_ff;

   // ------------------------------------------------------------------
   // Accept side: decode against forwarded banking, drive the stores
   // ------------------------------------------------------------------
   logic [BUS_ADDR_W-1:0]   req_addr;
   logic                    in_rd, in_wr, in_load;
   logic                    hit_low, hit_mid, hit_high, hit_win;
   logic                    win_rom;
   logic [OFFSET_W-1:0]     win_idx;
   logic [RomAddrWidth-1:0] rom_addr;
   logic                    rom_we, rom_re, ram_we, ram_re;

   always_comb begin
      req_addr = req_chan.address;
      in_rd    = req_chan.req_type == REQ_READ;
      in_wr    = req_chan.req_type == REQ_WRITE;
      in_load  = req_chan.req_type == REQ_LOAD;
      hit_low  = req_addr[12:11] == 2'b10;
      hit_mid  = (req_addr[12:11] == 2'b11) && (req_addr[10:9] != 2'b11);
      hit_high = req_addr[12:8] == 5'h1e;
      hit_win  = hit_low || hit_mid || hit_high;
      win_rom  = 1'b1;
      win_idx  = '0;
      if (hit_low) begin
         win_rom = state_fwd.win_rom[WIN_LOW];
         win_idx = {5'd0, req_addr[10:0]} + state_fwd.low_off;
      end else if (hit_mid) begin
         win_rom = state_fwd.win_rom[WIN_MID];
         win_idx = {5'd0, req_addr[10:0]} + state_fwd.mid_off;
      end else if (hit_high) begin
         win_rom = state_fwd.win_rom[WIN_HIGH];
         win_idx = {8'd0, req_addr[7:0]} + state_fwd.high_off;
      end
      // ROM port: load index, window index, or top page
      if (in_load) begin
         rom_addr = req_addr[RomAddrWidth-1:0];
      end else if (hit_win) begin
         rom_addr = win_idx[RomAddrWidth-1:0];
      end else begin
         rom_addr = {{(RomAddrWidth-8){1'b1}}, req_addr[7:0]};
      end
      rom_we = accept && in_load;
      rom_re = accept && in_rd && req_addr[12] && (!hit_win || win_rom);
      ram_we = accept && in_wr && hit_win && !win_rom;
      ram_re = accept && in_rd && hit_win && !win_rom;
   end

   // Memories
   always_ff @(posedge clock) begin
      if (rom_we) begin
         rom_mem[rom_addr] <= req_chan.write_data;
      end
      if (rom_re) begin
         rom_q_ff <= rom_mem[rom_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ram_we) begin
         ram_mem[win_idx[RamAddrWidth-1:0]] <= req_chan.write_data;
      end
      if (ram_re) begin
         ram_q_ff <= ram_mem[win_idx[RamAddrWidth-1:0]];
      end
   end

   // ------------------------------------------------------------------
   // Access stage: result byte and bank update
   // ------------------------------------------------------------------
   logic [DEC_ADDR_W-1:0] a;
   logic [BYTE_W-1:0]     bus;
   logic                  s1_rd, s1_wr, s1_access, qual, s1_win;
   peer_target_type       target;
   logic [BYTE_W-1:0]     value;

   always_comb begin
      a         = s1_addr_ff;
      bus       = s1_bus_ff;
      s1_rd     = s1_kind_ff == REQ_READ;
      s1_wr     = s1_kind_ff == REQ_WRITE;
      s1_access = s1_rd || s1_wr;
      s1_win    = a[12] && (a[12:8] != 5'h1f);
      qual      = (state_ff.prev_byte[7:5] == 3'b011) &&
                  (state_ff.prev_addr[12] || (state_ff.prev_addr[12:9] == 4'd0));
      target    = PEER_NONE;
      value     = '0;
      state_upd = state_ff;

      if (s1_access && !a[12]) begin
         // Peer decode
         if (a[7]) begin
            target = PEER_RIOT;
         end else if (!a[9]) begin
            target = PEER_TIA;
         end
         if (s1_rd && target != PEER_NONE) begin
            value = s1_peer_ff;
         end
         // Hotspots qualified by the last access
         if (qual) begin
            if (a[11:8] == 4'hc) begin
               state_upd.win_rom[WIN_HIGH] = 1'b1;
               state_upd.high_off          = {a[7:0], 8'd0};
            end else if (a[11:8] == 4'hd) begin
               state_upd.win_rom[WIN_HIGH] = 1'b0;
               state_upd.high_off          = {1'b0, a[6:0], 8'd0};
            end else if (a[11:8] == 4'he && !a[6]) begin
               state_upd.win_rom[WIN_LOW] = 1'b1;
               state_upd.low_off          = {a[4:0], 11'd0};
            end else if (a[11:8] == 4'he && a[6]) begin
               state_upd.win_rom[WIN_LOW] = 1'b0;
               state_upd.low_off          = {1'b0, a[3:0], 11'd0};
            end else if (a[11:8] == 4'hf && !a[6]) begin
               state_upd.win_rom[WIN_MID] = 1'b1;
               state_upd.mid_off          = {a[4:0], 11'd0};
            end else if (a[11:8] == 4'hf && a[6] && !a[4]) begin
               state_upd.win_rom[WIN_MID] = 1'b0;
               state_upd.mid_off          = {1'b0, a[3:0], 11'd0};
            end else if (a[11:8] == 4'h4) begin
               state_upd.low_off[11] = ~state_ff.low_off[11];
            end else if (a[11:8] == 4'h5) begin
               state_upd.low_off[12] = ~state_ff.low_off[12];
            end else if (a[11:8] == 4'h8) begin
               state_upd.mid_off[11] = ~state_ff.mid_off[11];
            end else if (a[11:8] == 4'h9) begin
               state_upd.mid_off[12] = ~state_ff.mid_off[12];
            end
         end
         // Zero-page hotspots take the bank from the bus byte
         if (a[11:8] == 4'h0 && a[6:4] == 3'b111 && a[2] && !a[0]) begin
            state_upd.win_rom[WIN_HIGH] = 1'b1;
            state_upd.high_off          = {bus, 8'd0};
         end else if (a[11:8] == 4'h0 && a[6:4] == 3'b111 && a[2] && a[0]) begin
            state_upd.win_rom[WIN_HIGH] = 1'b0;
            state_upd.high_off          = {1'b0, bus[6:0], 8'd0};
         end else if (a[11:8] == 4'h0 && a[6:4] == 3'b111 && a[3:2] == 2'b10) begin
            case (bus[7:4])
               4'h0: begin
                  state_upd.win_rom[WIN_LOW] = 1'b1;
                  state_upd.low_off          = {1'b0, bus[3:0], 11'd0};
               end
               4'h4: begin
                  state_upd.win_rom[WIN_LOW] = 1'b0;
                  state_upd.low_off          = {1'b0, bus[3:0], 11'd0};
               end
               4'h9: begin
                  state_upd.win_rom[WIN_MID] = 1'b1;
                  state_upd.mid_off          = {1'b1, bus[3:0], 11'd0};
               end
               4'hc: begin
                  state_upd.win_rom[WIN_MID] = 1'b0;
                  state_upd.mid_off          = {1'b0, bus[3:0], 11'd0};
               end
               default: begin
               end
            endcase
         end
      end else if (s1_access && s1_win) begin
         // Mapped window
         if (s1_rd) begin
            value = s1_rom_ff ? rom_q_ff : ram_q_ff;
         end
      end else if (s1_access) begin
         // Fixed top page of ROM
         if (s1_rd) begin
            value = rom_q_ff;
         end
         if (qual) begin
            state_upd.high_off[11:8] = {a[3], a[6:4]};
         end
      end

      if (s1_access) begin
         state_upd.prev_byte = s1_wr ? s1_wdata_ff : value;
         state_upd.prev_addr = a;
      end
   end

   // ------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------
   always_comb begin
      state_in = s1_move ? state_upd : state_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.low_off   <= '0;
         state_ff.mid_off   <= '0;
         state_ff.high_off  <= '0;
         state_ff.win_rom   <= 3'b111;
         state_ff.prev_byte <= 8'hff;
         state_ff.prev_addr <= 13'h1fff;
         s1_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff  <= req_chan.req_type;
         s1_addr_ff  <= req_chan.address[DEC_ADDR_W-1:0];
         s1_wdata_ff <= req_chan.write_data;
         s1_peer_ff  <= req_chan.peer_data;
         s1_bus_ff   <= req_chan.bus_state;
         s1_rom_ff   <= win_rom;
      end
      if (s1_move) begin
         read_data_ff   <= value;
         peer_target_ff <= target;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.read_data   = read_data_ff;
   assign rsp_chan.peer_target = peer_target_ff;

endmodule

### tb/cartridge_bank_mapper_4a50_tb.sv
// Testbench for the 4A50 bank mapper: directed bus accesses, then random hotspot traffic.
`timescale 1ns / 100ps

module cartridge_bank_mapper_4a50_tb
   import cbm_pkg::*;
();

   localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 1600;
   localparam int DRAIN_CYCLES = 20;
   // Address pages that select a qualified hotspot, and bus nibbles that select a window
   localparam logic [31:0] HOT_PAGES = 32'hcdef_4589;
   localparam logic [15:0] BUS_PAGES = 16'h049c;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      logic [BUS_ADDR_W-1:0] address;
      logic [BYTE_W-1:0]     write_data;
      logic [BYTE_W-1:0]     peer_data;
      logic [BYTE_W-1:0]     bus_state;
   } bus_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] read_data;
      peer_target_type   peer_target;
   } bank_result_type;

   typedef struct {
      logic [REQ_TYPE_W-1:0] kind;
      logic [BUS_ADDR_W-1:0] addr;
      logic [BYTE_W-1:0]     wd;
      logic [BYTE_W-1:0]     peer;
      logic [BYTE_W-1:0]     bus;
      bit                    typed;
      logic [BYTE_W-1:0]     data;
      peer_target_type       target;
   } probe_row_type;

   // Directed accesses; rows with typed set carry their own expected response
   probe_row_type probe_rows [27] = '{
      '{REQ_LOAD,   16'hff10, 8'h6a, 8'h00, 8'h00, 1'b1, 8'h00, PEER_NONE},
      '{REQ_LOAD,   16'hfdff, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, PEER_NONE},
      '{REQ_LOAD,   16'hffff, 8'hff, 8'h00, 8'h00, 1'b1, 8'h00, PEER_NONE},
      '{REQ_READ,   16'h1f10, 8'h00, 8'h00, 8'h00, 1'b1, 8'h6a, PEER_NONE},
      '{REQ_READ,   16'h1fff, 8'h00, 8'h00, 8'h00, 1'b1, 8'hff, PEER_NONE},
      '{REQ_READ,   16'h0080, 8'h00, 8'h5a, 8'h00, 1'b1, 8'h5a, PEER_RIOT},
      '{REQ_READ,   16'h0000, 8'h00, 8'ha5, 8'h00, 1'b1, 8'ha5, PEER_TIA},
      '{REQ_READ,   16'h0200, 8'h00, 8'h33, 8'h00, 1'b1, 8'h00, PEER_NONE},
      '{REQ_WRITE,  16'h0280, 8'h11, 8'h00, 8'h00, 1'b1, 8'h00, PEER_RIOT},
      '{REQ_UNUSED, 16'h1234, 8'h55, 8'h66, 8'h77, 1'b1, 8'h00, PEER_NONE},
      '{REQ_WRITE,  16'h1000, 8'h60, 8'h00, 8'h00, 1'b1, 8'h00, PEER_NONE},
      '{REQ_READ,   16'h0e4f, 8'h00, 8'h99, 8'h00, 1'b1, 8'h00, PEER_NONE},
      '{REQ_WRITE,  16'h17ff, 8'hff, 8'h00, 8'h00, 1'b1, 8'h00, PEER_NONE},
      '{REQ_READ,   16'h17ff, 8'h00, 8'h00, 8'h00, 1'b1, 8'hff, PEER_NONE},
      '{REQ_WRITE,  16'h1000, 8'h7f, 8'h00, 8'h00, 1'b1, 8'h00, PEER_NONE},
      '{REQ_READ,   16'h0d7f, 8'h00, 8'h42, 8'h00, 1'b1, 8'h42, PEER_TIA},
      '{REQ_WRITE,  16'h1eff, 8'h9c, 8'h00, 8'h00, 1'b1, 8'h00, PEER_NONE},
      '{REQ_READ,   16'h1eff, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, PEER_NONE},
      '{REQ_READ,   16'h0074, 8'h00, 8'h01, 8'hff, 1'b1, 8'h01, PEER_TIA},
      '{REQ_READ,   16'h1eff, 8'h00, 8'h00, 8'h00, 1'b1, 8'hff, PEER_NONE},
      '{REQ_READ,   16'h0078, 8'h00, 8'h00, 8'h9f, 1'b1, 8'h00, PEER_TIA},
      '{REQ_READ,   16'h1dff, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, PEER_NONE},
      '{REQ_READ,   16'h0079, 8'h00, 8'hfe, 8'hc5, 1'b1, 8'hfe, PEER_TIA},
      '{REQ_WRITE,  16'h1800, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, PEER_NONE},
      '{REQ_READ,   16'h1800, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, PEER_NONE},
      '{REQ_WRITE,  16'hffff, 8'h6e, 8'h00, 8'h00, 1'b1, 8'h00, PEER_NONE},
      '{REQ_READ,   16'h4c00, 8'h00, 8'h77, 8'h00, 1'b1, 8'h77, PEER_TIA}
   };

   logic clock;
   logic reset;

   cbm_req_if req_chan ();
   cbm_rsp_if rsp_chan ();

   cartridge_bank_mapper_4a50 dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Shadow of the mapper: stores, written-entry maps and banking state
   logic [BYTE_W-1:0] rom_img   [0:ROM_DEPTH_DEF-1];
   logic [BYTE_W-1:0] ram_img   [0:RAM_DEPTH_DEF-1];
   bit                rom_known [0:ROM_DEPTH_DEF-1];
   bit                ram_known [0:RAM_DEPTH_DEF-1];
   bank_state_type    bank;

   bank_result_type   expected_rsp [$];
   int                mismatch_count;
   int                random_items;
   bit                calm;
   logic [15:0]       recent_addr;

   always #6 clock = ~clock;

   // Store slot that an access at 0x1000-0x1fff touches
   function automatic void store_slot(input logic [15:0] a, output bit in_rom,
                                      output logic [15:0] idx);
      if (!a[11]) begin
         in_rom = bank.win_rom[WIN_LOW];
         idx    = {5'd0, a[10:0]} + bank.low_off;
      end else if (a[12:8] < 5'h1e) begin
         in_rom = bank.win_rom[WIN_MID];
         idx    = {5'd0, a[10:0]} + bank.mid_off;
      end else if (a[12:8] == 5'h1e) begin
         in_rom = bank.win_rom[WIN_HIGH];
         idx    = {8'd0, a[7:0]} + bank.high_off;
      end else begin
         in_rom = 1'b1;
         idx    = {8'hff, a[7:0]};
      end
   endfunction

   // Response of one bus access; updates the shadow state
   function automatic bank_result_type bank_access(input bus_item_type it);
      bank_result_type r;
      logic [15:0]     a;
      logic [11:0]     s;
      logic [15:0]     idx;
      logic [7:0]      bus;
      bit              wr;
      bit              qual;
      bit              in_rom;
      r    = '0;
      a    = it.address;
      s    = a[11:0];
      bus  = it.bus_state;
      wr   = (it.req_type == REQ_WRITE);
      qual = (bank.prev_byte[7:5] == 3'b011) &&
             ((bank.prev_addr >= 13'h1000) || (bank.prev_addr < 13'h0200));
      if (it.req_type == REQ_LOAD) begin
         rom_img[a]   = it.write_data;
         rom_known[a] = 1'b1;
         return r;
      end
      if (it.req_type == REQ_UNUSED)
         return r;

      if (!a[12]) begin
         // peer decode
         if (a[7])
            r.peer_target = PEER_RIOT;
         else if (!a[9])
            r.peer_target = PEER_TIA;
         if (!wr && r.peer_target != PEER_NONE)
            r.read_data = it.peer_data;
         // hotspots gated by the previous access
         if (qual) begin
            if (s[11:8] == 4'hc) begin
               bank.win_rom[WIN_HIGH] = 1'b1;
               bank.high_off = {a[7:0], 8'h00};
            end else if (s[11:8] == 4'hd) begin
               bank.win_rom[WIN_HIGH] = 1'b0;
               bank.high_off = {1'b0, a[6:0], 8'h00};
            end else if ((s & 12'hf40) == 12'he00) begin
               bank.win_rom[WIN_LOW] = 1'b1;
               bank.low_off = {a[4:0], 11'd0};
            end else if ((s & 12'hf40) == 12'he40) begin
               bank.win_rom[WIN_LOW] = 1'b0;
               bank.low_off = {1'b0, a[3:0], 11'd0};
            end else if ((s & 12'hf40) == 12'hf00) begin
               bank.win_rom[WIN_MID] = 1'b1;
               bank.mid_off = {a[4:0], 11'd0};
            end else if ((s & 12'hf50) == 12'hf40) begin
               bank.win_rom[WIN_MID] = 1'b0;
               bank.mid_off = {1'b0, a[3:0], 11'd0};
            end else if (s[11:8] == 4'h4) begin
               bank.low_off ^= 16'h0800;
            end else if (s[11:8] == 4'h5) begin
               bank.low_off ^= 16'h1000;
            end else if (s[11:8] == 4'h8) begin
               bank.mid_off ^= 16'h0800;
            end else if (s[11:8] == 4'h9) begin
               bank.mid_off ^= 16'h1000;
            end
         end
         // hotspots fed by the bus byte; these win over the gated ones
         if ((s & 12'hf75) == 12'h074) begin
            bank.win_rom[WIN_HIGH] = 1'b1;
            bank.high_off = {bus, 8'h00};
         end else if ((s & 12'hf75) == 12'h075) begin
            bank.win_rom[WIN_HIGH] = 1'b0;
            bank.high_off = {1'b0, bus[6:0], 8'h00};
         end else if ((s & 12'hf7c) == 12'h078) begin
            case (bus[7:4])
               4'h0: begin
                  bank.win_rom[WIN_LOW] = 1'b1;
                  bank.low_off = {1'b0, bus[3:0], 11'd0};
               end
               4'h4: begin
                  bank.win_rom[WIN_LOW] = 1'b0;
                  bank.low_off = {1'b0, bus[3:0], 11'd0};
               end
               4'h9: begin
                  bank.win_rom[WIN_MID] = 1'b1;
                  bank.mid_off = {1'b1, bus[3:0], 11'd0};
               end
               4'hc: begin
                  bank.win_rom[WIN_MID] = 1'b0;
                  bank.mid_off = {1'b0, bus[3:0], 11'd0};
               end
               default: ;
            endcase
         end
      end else begin
         store_slot(a, in_rom, idx);
         if (in_rom) begin
            // writes to ROM are dropped
            if (!wr)
               r.read_data = rom_img[idx];
         end else if (wr) begin
            ram_img[idx[14:0]]   = it.write_data;
            ram_known[idx[14:0]] = 1'b1;
         end else begin
            r.read_data = ram_img[idx[14:0]];
         end
         // a qualified top page access reloads bits 11..8 of the high offset
         if (a[12:8] == 5'h1f && qual)
            bank.high_off[11:8] = {a[3], a[6:4]};
      end

      bank.prev_byte = wr ? it.write_data : r.read_data;
      bank.prev_addr = a[12:0];
      return r;
   endfunction

   // ROM content leans toward bytes that qualify the next hotspot
   function automatic logic [7:0] rom_fill_byte();
      logic [7:0] b;
      b = 8'($urandom);
      if ($urandom_range(3) == 0)
         b[7:5] = 3'b011;
      return b;
   endfunction

   // Write that qualifies the following hotspot access
   function automatic bus_item_type qualifier_item();
      bus_item_type q;
      q.req_type   = REQ_WRITE;
      q.address    = 16'($urandom);
      q.write_data = 8'($urandom);
      q.peer_data  = 8'($urandom);
      q.bus_state  = 8'($urandom);
      q.write_data[7:5] = 3'b011;
      if ($urandom_range(3) == 0)
         q.address[12:9] = 4'b0000;
      else
         q.address[12] = 1'b1;
      return q;
   endfunction

   // Drive one transaction, wait for acceptance, then record its expected response
   task automatic send(input bus_item_type it, input bit typed,
                       input bank_result_type want);
      bank_result_type got;
      while (!calm && $urandom_range(99) < 9) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.req_type   <= it.req_type;
      req_chan.address    <= it.address;
      req_chan.write_data <= it.write_data;
      req_chan.peer_data  <= it.peer_data;
      req_chan.bus_state  <= it.bus_state;
      @(posedge clock);
      while (!(req_chan.valid && req_chan.ready))
         @(posedge clock);
      got = bank_access(it);
      expected_rsp.push_back(typed ? want : got);
   endtask

   // Random access; reads of never-written entries get a ROM load first or become RAM writes
   task automatic issue(input bus_item_type it);
      bus_item_type fill;
      bit           in_rom;
      logic [15:0]  idx;
      if (it.req_type == REQ_READ && it.address[12]) begin
         store_slot(it.address, in_rom, idx);
         if (in_rom && !rom_known[idx]) begin
            fill.req_type   = REQ_LOAD;
            fill.address    = idx;
            fill.write_data = rom_fill_byte();
            fill.peer_data  = 8'($urandom);
            fill.bus_state  = 8'($urandom);
            send(fill, 1'b0, '0);
         end else if (!in_rom && !ram_known[idx[14:0]]) begin
            it.req_type = REQ_WRITE;
         end
      end
      if (it.req_type == REQ_WRITE && it.address[12])
         recent_addr = it.address;
      send(it, 1'b0, '0);
      random_items++;
   endtask

   // Response check and random back-pressure
   always @(posedge clock) begin
      bank_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_rsp.size() == 0) begin
            $error("unexpected response: read_data %02h peer_target %0d",
                   rsp_chan.read_data, rsp_chan.peer_target);
            mismatch_count++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_chan.read_data !== want.read_data) begin
               $error("read_data: expected %02h, got %02h", want.read_data,
                      rsp_chan.read_data);
               mismatch_count++;
            end
            if (rsp_chan.peer_target !== want.peer_target) begin
               $error("peer_target: expected %0d, got %0d", want.peer_target,
                      rsp_chan.peer_target);
               mismatch_count++;
            end
         end
      end
      rsp_chan.ready <= calm || ($urandom_range(99) >= 9);
   end

   // Stimulus
   initial begin
      bus_item_type it;
      logic [15:0]  m;
      int           pick;
      clock               = 1'b0;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.req_type   = REQ_READ;
      req_chan.address    = '0;
      req_chan.write_data = '0;
      req_chan.peer_data  = '0;
      req_chan.bus_state  = '0;
      rsp_chan.ready      = 1'b0;
      mismatch_count      = 0;
      random_items        = 0;
      calm                = 1'b0;
      recent_addr         = 16'h1000;
      bank.low_off        = '0;
      bank.mid_off        = '0;
      bank.high_off       = '0;
      bank.win_rom        = 3'b111;
      bank.prev_byte      = 8'hff;
      bank.prev_addr      = 13'h1fff;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed accesses
      foreach (probe_rows[k]) begin
         it.req_type   = probe_rows[k].kind;
         it.address    = probe_rows[k].addr;
         it.write_data = probe_rows[k].wd;
         it.peer_data  = probe_rows[k].peer;
         it.bus_state  = probe_rows[k].bus;
         send(it, probe_rows[k].typed, '{probe_rows[k].data, probe_rows[k].target});
      end

      // hold off until every response is back
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_rsp.size() != 0)
         @(posedge clock);

      // random traffic, mostly qualifier/hotspot pairs and window accesses
      while (random_items < RANDOM_ITEMS) begin
         calm          = (random_items >= 700 && random_items < 1000);
         pick          = $urandom_range(99);
         m             = 16'($urandom);
         it.req_type   = $urandom_range(1) ? REQ_WRITE : REQ_READ;
         it.address    = 16'($urandom);
         it.write_data = 8'($urandom);
         it.peer_data  = 8'($urandom);
         it.bus_state  = 8'($urandom);
         if (pick < 30) begin
            issue(qualifier_item());
            it.address[12:8] = {1'b0, HOT_PAGES[4 * $urandom_range(7) +: 4]};
         end else if (pick < 45) begin
            it.address[12] = 1'b0;
            case ($urandom_range(2))
               0:       it.address[11:0] = 12'h074 | (12'h08a & m[11:0]);
               1:       it.address[11:0] = 12'h075 | (12'h08a & m[11:0]);
               default: it.address[11:0] = 12'h078 | (12'h083 & m[11:0]);
            endcase
            if ($urandom_range(3) != 0)
               it.bus_state[7:4] = BUS_PAGES[4 * $urandom_range(3) +: 4];
         end else if (pick < 75) begin
            it.address[12] = 1'b1;
            if (it.req_type == REQ_READ && $urandom_range(2) == 0)
               it.address = recent_addr;
         end else if (pick < 85) begin
            if ($urandom_range(1))
               issue(qualifier_item());
            it.address[12:8] = 5'h1f;
         end else if (pick < 93) begin
            it.req_type   = REQ_LOAD;
            it.write_data = rom_fill_byte();
         end else begin
            it.req_type = 2'($urandom_range(3));
         end
         issue(it);
      end
      calm = 1'b0;

      // drain
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Run limit
   initial begin
      #6000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
